FILE: design/cwsa_pkg.sv
// ----------------------------------------------------------------------------
// cwsa_pkg: shared types, constants and microcode for the slot allocator
// Holds the credit arithmetic helpers, the control word layout and the
// read-only control program that sequences one round.
// ----------------------------------------------------------------------------
package cwsa_pkg;

    // Sizing
    localparam int KINDS        = 5;
    localparam int SLOTS        = 3;
    localparam int CREDIT_WIDTH = 16;

    localparam int KIND_IDX_W = (KINDS > 1) ? $clog2(KINDS) : 1;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths fixed by the port list
    localparam int SHARE_W = 4;
    localparam int GAIN_W  = 4;
    localparam int COST_W  = 5;
    localparam int MODE_W  = 2;
    localparam int MASK_W  = 5;
    localparam int ID_W    = 3;
    localparam int EMPTY_W = 2;

    // Configuration port
    localparam int CFG_COUNT  = KINDS + 3;
    localparam int CFG_IDX_W  = $clog2(CFG_COUNT);
    localparam int CFG_DATA_W = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GAIN = t_cfg_idx'(KINDS);
    localparam t_cfg_idx CFG_COST = t_cfg_idx'(KINDS + 1);
    localparam t_cfg_idx CFG_MODE = t_cfg_idx'(KINDS + 2);

    // Rule modes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_NORMAL   = 2'd0;
    localparam t_mode MODE_HIGH_TIE = 2'd1;
    localparam t_mode MODE_CLAMP    = 2'd2;

    // Credit types
    typedef logic signed [CREDIT_WIDTH-1:0] t_credit;
    typedef logic signed [CREDIT_WIDTH:0]   t_credit_ext;

    typedef logic [ID_W-1:0]       t_kind_id;
    typedef logic [KIND_IDX_W-1:0] t_kind_idx;
    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;

    // Saturate a one-bit-wider result back to the credit width
    function automatic t_credit sat_credit(input t_credit_ext v);
        t_credit r;
        r = v[CREDIT_WIDTH-1:0];
        if (!v[CREDIT_WIDTH] && v[CREDIT_WIDTH-1]) begin
            r = {1'b0, {(CREDIT_WIDTH-1){1'b1}}};
        end else if (v[CREDIT_WIDTH] && !v[CREDIT_WIDTH-1]) begin
            r = {1'b1, {(CREDIT_WIDTH-1){1'b0}}};
        end
        return r;
    endfunction

    // Microcode
    typedef enum logic [1:0] {
        OP_WAIT,
        OP_GROW,
        OP_PICK,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_LAST_SLOT,
        COND_OUT_FREE
    } t_cond;

    typedef logic [1:0] t_upc;

    localparam t_upc UPC_WAIT = 2'd0;
    localparam t_upc UPC_GROW = 2'd1;
    localparam t_upc UPC_PICK = 2'd2;
    localparam t_upc UPC_EMIT = 2'd3;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_ctrl;

    // Control program: jump to target when the condition holds, else hold
    function automatic t_ctrl ucode(input t_upc pc);
        t_ctrl w;
        case (pc)
            UPC_WAIT: w = '{op: OP_WAIT, cond: COND_IN_BEAT,   target: UPC_GROW};
            UPC_GROW: w = '{op: OP_GROW, cond: COND_ALWAYS,    target: UPC_PICK};
            UPC_PICK: w = '{op: OP_PICK, cond: COND_LAST_SLOT, target: UPC_EMIT};
            UPC_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_FREE,  target: UPC_WAIT};
            default:  w = '{op: OP_WAIT, cond: COND_ALWAYS,    target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: design/credit_weighted_slot_allocator_core.sv
// A round is taken when o_in_ready is high, which is whenever the sequencer
// sits at its wait step. From the accepted beat to the result register the
// round runs one grow step, one pick step per slot and the emit step. The
// sequencer returns to its wait step at the emit edge, so the next round is
// taken in the cycle after that; a new round is not taken while one is in
// progress. The pace is set by the single shared max-credit picker, which is
// stepped once per slot; a result that is not taken stalls the emit step
// until the output register frees up.
// ----------------------------------------------------------------------------
// credit_weighted_slot_allocator_core: credit weighted slot allocator
// Microcoded smooth weighted round robin: grows every kind's credit by
// gain * share, then fills each slot with the eligible kind of largest
// credit and charges it the slot cost.
// ----------------------------------------------------------------------------
module credit_weighted_slot_allocator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cwsa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cwsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // round input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cwsa_pkg::MASK_W-1:0]        i_eligible_mask,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cwsa_pkg::ID_W-1:0]          o_slot_first,
    output logic [cwsa_pkg::ID_W-1:0]          o_slot_second,
    output logic [cwsa_pkg::ID_W-1:0]          o_slot_third,
    output logic [cwsa_pkg::EMPTY_W-1:0]       o_empty_slots
);

    // Configuration registers
    logic [cwsa_pkg::SHARE_W-1:0] r_share [cwsa_pkg::KINDS];
    logic [cwsa_pkg::GAIN_W-1:0]  r_gain;
    logic [cwsa_pkg::COST_W-1:0]  r_cost;
    cwsa_pkg::t_mode              r_mode;

    // Sequencer and datapath state
    cwsa_pkg::t_upc               r_upc, n_upc;
    cwsa_pkg::t_ctrl              ctrl;
    logic                         cond_hit;
    cwsa_pkg::t_credit            r_credit [cwsa_pkg::KINDS];
    logic [cwsa_pkg::MASK_W-1:0]  r_mask;
    cwsa_pkg::t_slot_idx          r_slot_idx;
    cwsa_pkg::t_kind_id           r_slot [cwsa_pkg::SLOTS];
    logic [cwsa_pkg::EMPTY_W-1:0] r_empty;

    // Output register
    logic                         r_out_valid;
    cwsa_pkg::t_kind_id           r_out_slot [cwsa_pkg::SLOTS];
    logic [cwsa_pkg::EMPTY_W-1:0] r_out_empty;

    logic                         in_beat;
    logic                         out_free;
    logic                         last_slot;

    // Picker and charge path
    logic                         pick_found;
    cwsa_pkg::t_kind_idx          pick_idx;
    cwsa_pkg::t_credit            pick_credit;
    cwsa_pkg::t_credit            charged;
    cwsa_pkg::t_credit            grown [cwsa_pkg::KINDS];

    // Fetch the control word for this step
    assign ctrl      = cwsa_pkg::ucode(r_upc);
    assign o_in_ready = (ctrl.op == cwsa_pkg::OP_WAIT);
    assign in_beat   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_slot = (r_slot_idx == cwsa_pkg::t_slot_idx'(cwsa_pkg::SLOTS - 1));

    // Evaluate the jump condition
    always_comb begin
        case (ctrl.cond)
            cwsa_pkg::COND_ALWAYS:    cond_hit = 1'b1;
            cwsa_pkg::COND_IN_BEAT:   cond_hit = in_beat;
            cwsa_pkg::COND_LAST_SLOT: cond_hit = last_slot;
            cwsa_pkg::COND_OUT_FREE:  cond_hit = out_free;
            default:                  cond_hit = 1'b0;
        endcase
        n_upc = cond_hit ? ctrl.target : r_upc;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= cwsa_pkg::UPC_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Grow every credit by gain * share, saturating
    always_comb begin
        for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
            grown[k] = cwsa_pkg::sat_credit(
                cwsa_pkg::t_credit_ext'(r_credit[k])
                + cwsa_pkg::t_credit_ext'({1'b0,
                    ({{cwsa_pkg::SHARE_W{1'b0}}, r_gain}
                     * {{cwsa_pkg::GAIN_W{1'b0}}, r_share[k]})}));
        end
    end

    // Find the eligible kind with the largest credit
    always_comb begin
        pick_found  = 1'b0;
        pick_idx    = '0;
        pick_credit = '0;
        for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
            if (r_mask[k] && (!pick_found || (r_credit[k] > pick_credit)
                    || ((r_mode == cwsa_pkg::MODE_HIGH_TIE)
                        && (r_credit[k] == pick_credit)))) begin
                pick_found  = 1'b1;
                pick_idx    = cwsa_pkg::t_kind_idx'(k);
                pick_credit = r_credit[k];
            end
        end
    end

    // Charge the winner, with optional clamp at zero
    always_comb begin
        charged = cwsa_pkg::sat_credit(
            cwsa_pkg::t_credit_ext'(pick_credit)
            - cwsa_pkg::t_credit_ext'({1'b0, r_cost}));
        if ((r_mode == cwsa_pkg::MODE_CLAMP) && charged[cwsa_pkg::CREDIT_WIDTH-1]) begin
            charged = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
                r_share[k] <= cwsa_pkg::SHARE_W'(1);
            end
            r_gain <= cwsa_pkg::GAIN_W'(3);
            r_cost <= cwsa_pkg::COST_W'(5);
            r_mode <= cwsa_pkg::MODE_NORMAL;
        end else if (i_cfg_we) begin
            for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
                if (i_cfg_idx == cwsa_pkg::t_cfg_idx'(k)) begin
                    r_share[k] <= i_cfg_data[cwsa_pkg::SHARE_W-1:0];
                end
            end
            if (i_cfg_idx == cwsa_pkg::CFG_GAIN) begin
                r_gain <= i_cfg_data[cwsa_pkg::GAIN_W-1:0];
            end
            if (i_cfg_idx == cwsa_pkg::CFG_COST) begin
                r_cost <= i_cfg_data[cwsa_pkg::COST_W-1:0];
            end
            if (i_cfg_idx == cwsa_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data[cwsa_pkg::MODE_W-1:0];
            end
        end
    end

    // Credit state: grow step and charge step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
                r_credit[k] <= '0;
            end
        end else if (ctrl.op == cwsa_pkg::OP_GROW) begin
            for (int k = 0; k < cwsa_pkg::KINDS; k++) begin
                r_credit[k] <= grown[k];
            end
        end else if ((ctrl.op == cwsa_pkg::OP_PICK) && pick_found) begin
            r_credit[pick_idx] <= charged;
        end
    end

    // Round working registers: mask, slot counter, slot ids, empty count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_idx <= '0;
            r_empty    <= '0;
        end else if (in_beat) begin
            r_mask     <= i_eligible_mask;
            r_slot_idx <= '0;
            r_empty    <= '0;
        end else if (ctrl.op == cwsa_pkg::OP_PICK) begin
            r_slot_idx <= last_slot ? '0 : r_slot_idx + 1'b1;
            if (pick_found) begin
                r_slot[r_slot_idx] <= cwsa_pkg::t_kind_id'(pick_idx) + 1'b1;
            end else begin
                r_slot[r_slot_idx] <= '0;
                r_empty            <= r_empty + 1'b1;
            end
        end
    end

    // Output register: load on emit, drop on the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((ctrl.op == cwsa_pkg::OP_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((ctrl.op == cwsa_pkg::OP_EMIT) && out_free) begin
            r_out_slot  <= r_slot;
            r_out_empty <= r_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_first  = r_out_slot[0];
    assign o_slot_second = r_out_slot[1];
    assign o_slot_third  = r_out_slot[2];
    assign o_empty_slots = r_out_empty;

endmodule

FILE: design/cwsa_checker.sv
// ----------------------------------------------------------------------------
// cwsa_checker: port-level checks for the slot allocator
// Watches the top level's ports and flags inconsistent results or handshake
// slips; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module cwsa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [cwsa_pkg::ID_W-1:0]          o_slot_first,
    input logic [cwsa_pkg::ID_W-1:0]          o_slot_second,
    input logic [cwsa_pkg::ID_W-1:0]          o_slot_third,
    input logic [cwsa_pkg::EMPTY_W-1:0]       o_empty_slots
);

    // A held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_slot_first)
            && $stable(o_slot_second) && $stable(o_slot_third)
            && $stable(o_empty_slots)))
        else $error("result beat changed while stalled");

    // Empty count matches the number of zero slot ids
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_slots == cwsa_pkg::EMPTY_W'(
            (o_slot_first == '0) + (o_slot_second == '0) + (o_slot_third == '0))))
        else $error("empty_slots disagrees with slot ids");

    // Either every slot is filled or the round had no eligible kind
    a_all_or_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_slot_first == '0)) |->
            ((o_slot_second == '0) && (o_slot_third == '0)))
        else $error("partially empty round");

    // Slot ids stay within the kind range
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_slot_first <= cwsa_pkg::ID_W'(cwsa_pkg::KINDS))
            && (o_slot_second <= cwsa_pkg::ID_W'(cwsa_pkg::KINDS))
            && (o_slot_third <= cwsa_pkg::ID_W'(cwsa_pkg::KINDS))))
        else $error("slot id beyond kind count");

    // A round is worked on before the next one is taken
    a_one_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a round is in progress");

endmodule

bind credit_weighted_slot_allocator_core cwsa_checker u_cwsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_slot_first  (o_slot_first),
    .o_slot_second (o_slot_second),
    .o_slot_third  (o_slot_third),
    .o_empty_slots (o_empty_slots)
);
